// File: sv/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types and constants for the integer to ASCII formatter: the
// microcode word layout, the datapath status bundle and character codes.
// ----------------------------------------------------------------------------
package i2a_pkg;

   // Number of BCD digits kept by the datapath and their total width.
   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned DIGIT_BITS = 4 * NUM_DIGITS;

   // Digit counts that the load step starts from in each mode.
   localparam logic [3:0] DEC_DIGITS = 4'd10;
   localparam logic [3:0] HEX_DIGITS = 4'd8;

   // Last index of the 32 double dabble iterations.
   localparam logic [4:0] LOOP_LAST = 5'd31;

   // ASCII codes used by the output stage.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;

   // Input command codes.
   localparam logic CMD_DEC = 1'b0;
   localparam logic CMD_HEX = 1'b1;

   // Micro-program counter.
   typedef logic [2:0] upc_type;

   // Datapath operations.
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_DABBLE,
      OP_STRIP,
      OP_MINUS,
      OP_DIGIT
   } op_type;

   // Jump conditions.
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_HEX,
      C_LOOP,
      C_LEAD_ZERO,
      C_NOT_NEG,
      C_MORE
   } cond_type;

   // One control word of the microcode store.
   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } ctrl_word_type;

   // Status flags reported by the datapath to the sequencer.
   typedef struct packed {
      logic hex;
      logic neg;
      logic loop_more;
      logic lead_zero;
      logic more;
      logic slot_free;
   } status_type;

   // Micro-program entry points.
   localparam upc_type UPC_IDLE   = 3'd0;
   localparam upc_type UPC_MODE   = 3'd1;
   localparam upc_type UPC_DABBLE = 3'd2;
   localparam upc_type UPC_STRIP  = 3'd3;
   localparam upc_type UPC_SIGN   = 3'd4;
   localparam upc_type UPC_MINUS  = 3'd5;
   localparam upc_type UPC_DIGIT  = 3'd6;
   localparam upc_type UPC_DONE   = 3'd7;

endpackage

// File: sv/i2a_ctrl_rom.sv
// ----------------------------------------------------------------------------
// i2a_ctrl_rom
// Read-only control store: one control word per micro-program step.
// ----------------------------------------------------------------------------
module i2a_ctrl_rom (
   input  i2a_pkg::upc_type       upc,
   output i2a_pkg::ctrl_word_type ctrl
);

   // The micro-program. A step jumps to its target when its condition holds.
   always_comb begin
      unique case (upc)
         i2a_pkg::UPC_IDLE:   ctrl = '{i2a_pkg::OP_LOAD,   i2a_pkg::C_NEVER,
                                       i2a_pkg::UPC_IDLE};
         i2a_pkg::UPC_MODE:   ctrl = '{i2a_pkg::OP_NOP,    i2a_pkg::C_HEX,
                                       i2a_pkg::UPC_STRIP};
         i2a_pkg::UPC_DABBLE: ctrl = '{i2a_pkg::OP_DABBLE, i2a_pkg::C_LOOP,
                                       i2a_pkg::UPC_DABBLE};
         i2a_pkg::UPC_STRIP:  ctrl = '{i2a_pkg::OP_STRIP,  i2a_pkg::C_LEAD_ZERO,
                                       i2a_pkg::UPC_STRIP};
         i2a_pkg::UPC_SIGN:   ctrl = '{i2a_pkg::OP_NOP,    i2a_pkg::C_NOT_NEG,
                                       i2a_pkg::UPC_DIGIT};
         i2a_pkg::UPC_MINUS:  ctrl = '{i2a_pkg::OP_MINUS,  i2a_pkg::C_NEVER,
                                       i2a_pkg::UPC_IDLE};
         i2a_pkg::UPC_DIGIT:  ctrl = '{i2a_pkg::OP_DIGIT,  i2a_pkg::C_MORE,
                                       i2a_pkg::UPC_DIGIT};
         i2a_pkg::UPC_DONE:   ctrl = '{i2a_pkg::OP_NOP,    i2a_pkg::C_ALWAYS,
                                       i2a_pkg::UPC_IDLE};
         default:             ctrl = '{i2a_pkg::OP_NOP,    i2a_pkg::C_ALWAYS,
                                       i2a_pkg::UPC_IDLE};
      endcase
   end

endmodule

// File: sv/i2a_sequencer.sv
// ----------------------------------------------------------------------------
// i2a_sequencer
// Micro-program counter with conditional jumps and wait handling.
// ----------------------------------------------------------------------------
module i2a_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  i2a_pkg::ctrl_word_type ctrl,
   input  i2a_pkg::status_type    status,
   input  logic                   req_valid,
   output i2a_pkg::upc_type       upc,
   output logic                   go
);

   i2a_pkg::upc_type upc_ff;
   i2a_pkg::upc_type upc_in;
   logic             taken;

   // A load waits for a transaction, a character waits for a free output slot.
   always_comb begin
      unique case (ctrl.op) inside
         i2a_pkg::OP_LOAD:  go = req_valid;
         i2a_pkg::OP_MINUS,
         i2a_pkg::OP_DIGIT: go = status.slot_free;
         default:           go = 1'b1;
      endcase
   end

   // Jump condition decode.
   always_comb begin
      unique case (ctrl.cond)
         i2a_pkg::C_NEVER:     taken = 1'b0;
         i2a_pkg::C_ALWAYS:    taken = 1'b1;
         i2a_pkg::C_HEX:       taken = status.hex;
         i2a_pkg::C_LOOP:      taken = status.loop_more;
         i2a_pkg::C_LEAD_ZERO: taken = status.lead_zero;
         i2a_pkg::C_NOT_NEG:   taken = !status.neg;
         i2a_pkg::C_MORE:      taken = status.more;
         default:              taken = 1'b0;
      endcase
   end

   // Next step: hold while waiting, else jump or fall through.
   always_comb begin
      if (!go) begin
         upc_in = upc_ff;
      end else if (taken) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = upc_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= i2a_pkg::UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign upc = upc_ff;

endmodule

// File: sv/i2a_datapath.sv
// ----------------------------------------------------------------------------
// i2a_datapath
// Magnitude and BCD registers, double dabble step, leading zero strip and
// the registered output stage.
// ----------------------------------------------------------------------------
module i2a_datapath (
   input  logic                clock,
   input  logic                reset,
   input  i2a_pkg::op_type     op,
   input  logic                go,
   input  logic                req_cmd,
   input  logic [31:0]         req_value,
   input  logic                rsp_ready,
   output i2a_pkg::status_type status,
   output logic                rsp_valid,
   output logic [7:0]          rsp_ch,
   output logic                rsp_last
);

   logic [31:0]                      mag_ff, mag_in;
   logic [i2a_pkg::DIGIT_BITS-1:0]   digits_ff, digits_in;
   logic [i2a_pkg::DIGIT_BITS-1:0]   adjusted;
   logic [3:0]                       cnt_ff, cnt_in;
   logic [4:0]                       loop_ff, loop_in;
   logic                             hex_ff, hex_in;
   logic                             neg_ff, neg_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_ch_ff, rsp_ch_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [3:0]                       top_nib;
   logic                             in_neg;
   logic [7:0]                       nib_char;

   assign top_nib = digits_ff[i2a_pkg::DIGIT_BITS-1 -: 4];
   assign in_neg  = (req_cmd == i2a_pkg::CMD_DEC) && req_value[31];

   // Character for the leading nibble.
   always_comb begin
      if (top_nib < 4'd10) begin
         nib_char = i2a_pkg::CHAR_ZERO + {4'd0, top_nib};
      end else begin
         nib_char = i2a_pkg::CHAR_A + {4'd0, top_nib - 4'd10};
      end
   end

   // Add three to every BCD digit of five or more ahead of the shift.
   always_comb begin
      for (int i = 0; i < i2a_pkg::NUM_DIGITS; i++) begin
         if (digits_ff[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = digits_ff[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = digits_ff[4*i +: 4];
         end
      end
   end

   // Status flags for the sequencer.
   always_comb begin
      status.hex       = hex_ff;
      status.neg       = neg_ff;
      status.loop_more = loop_ff != i2a_pkg::LOOP_LAST;
      status.lead_zero = (top_nib == 4'd0) && (cnt_ff != 4'd1);
      status.more      = cnt_ff != 4'd1;
      status.slot_free = !rsp_valid_ff || rsp_ready;
   end

   // Datapath operation decode.
   always_comb begin
      mag_in       = mag_ff;
      digits_in    = digits_ff;
      cnt_in       = cnt_ff;
      loop_in      = loop_ff;
      hex_in       = hex_ff;
      neg_in       = neg_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (go) begin
         unique case (op)
            i2a_pkg::OP_LOAD: begin
               hex_in  = req_cmd;
               neg_in  = in_neg;
               mag_in  = in_neg ? (32'd0 - req_value) : req_value;
               loop_in = 5'd0;
               if (req_cmd == i2a_pkg::CMD_HEX) begin
                  digits_in = {req_value, {(i2a_pkg::DIGIT_BITS-32){1'b0}}};
                  cnt_in    = i2a_pkg::HEX_DIGITS;
               end else begin
                  digits_in = '0;
                  cnt_in    = i2a_pkg::DEC_DIGITS;
               end
            end
            i2a_pkg::OP_DABBLE: begin
               {digits_in, mag_in} = {adjusted, mag_ff} << 1;
               loop_in             = loop_ff + 5'd1;
            end
            i2a_pkg::OP_STRIP: begin
               if (status.lead_zero) begin
                  digits_in = digits_ff << 4;
                  cnt_in    = cnt_ff - 4'd1;
               end
            end
            i2a_pkg::OP_MINUS: begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = i2a_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
            end
            i2a_pkg::OP_DIGIT: begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = nib_char;
               rsp_last_in  = cnt_ff == 4'd1;
               digits_in    = digits_ff << 4;
               cnt_in       = cnt_ff - 4'd1;
            end
            default: begin
            end
         endcase
      end
   end

   // Registers; only the output valid bit sees reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      digits_ff   <= digits_in;
      cnt_ff      <= cnt_in;
      loop_ff     <= loop_in;
      hex_ff      <= hex_in;
      neg_ff      <= neg_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ch    = rsp_ch_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// File: sv/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Converts a 32-bit value to signed decimal or lowercase hex ASCII text.
// ----------------------------------------------------------------------------
// Sequence: a decimal transaction passes the load, mode, double dabble, strip
// and sign steps, then the minus step if it is negative, before its first
// character; a hex one skips the dabble loop. The strip removes up to 9 leading
// zeros in decimal and 7 in hex. A full output register stalls the character
// steps and with them the next transaction, which is taken only after the last
// character of the one before has been issued.
// Reset: synchronous; returns the micro-program to its idle step and empties
// the output register.
module integer_to_ascii_formatter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_ch,
   output logic        rsp_last
);

   i2a_pkg::upc_type       upc;
   i2a_pkg::ctrl_word_type ctrl;
   i2a_pkg::status_type    status;
   logic                   go;

   // Control store lookup.
   i2a_ctrl_rom u_rom (
      .upc  (upc),
      .ctrl (ctrl)
   );

   // Step counter and jump logic.
   i2a_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_valid (req_valid),
      .upc       (upc),
      .go        (go)
   );

   // Conversion datapath and output register.
   i2a_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (ctrl.op),
      .go        (go),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .rsp_ready (rsp_ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ch    (rsp_ch),
      .rsp_last  (rsp_last)
   );

   // A new transaction is taken only on the load step.
   assign req_ready = ctrl.op == i2a_pkg::OP_LOAD;

endmodule

// File: sv/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks for the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module i2a_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_cmd,
   input logic [31:0] req_value,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_ch,
   input logic        rsp_last
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ch) && $stable(rsp_last))
      else $error("result changed while stalled");

   // The block is busy right after it takes a transaction.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after accept");

   // A minus sign is never the last character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ch == i2a_pkg::CHAR_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last");

   // Only digits, lowercase hex letters and minus appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ch >= i2a_pkg::CHAR_ZERO &&
                     rsp_ch <= i2a_pkg::CHAR_ZERO + 8'd9) ||
                    (rsp_ch >= i2a_pkg::CHAR_A && rsp_ch <= i2a_pkg::CHAR_A + 8'd5) ||
                    rsp_ch == i2a_pkg::CHAR_MINUS)
      else $error("character outside the output alphabet");

   // A waiting request stays offered with its payload unchanged.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_cmd) && $stable(req_value))
      else $error("request dropped or changed while waiting");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (.*);
